// ===== src/svpwm_pkg.sv =====
package svpwm_pkg;

    typedef struct packed {
        logic signed [15:0] voltage_q;
        logic signed [15:0] voltage_d;
        logic        [15:0] electrical_angle;
    } t_svpwm_in;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
    } t_svpwm_out;

    typedef enum logic [1:0] {
        REG_VOLTAGE_LIMIT = 2'd0,
        REG_INV_BUS       = 2'd1,
        REG_PWM_PERIOD    = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    localparam logic [14:0] LIMIT_RESET   = 15'd1536;
    localparam logic [15:0] INV_BUS_RESET = 16'd5406;
    localparam logic [15:0] PERIOD_RESET  = 16'd8500;

    localparam logic signed [16:0] HALF_SQRT3_Q16 = 17'sd56756;

    localparam int DUTY_FRAC = 26;

    localparam longint SIN_C1 = 64'sd1686629713;
    localparam longint SIN_C3 = 64'sd693598668;
    localparam longint SIN_C5 = 64'sd85569306;
    localparam longint SIN_C7 = 64'sd5026995;
    localparam longint SIN_C9 = 64'sd172272;

endpackage

// ===== src/svpwm_min_max_injection.sv =====
// Space vector PWM with min-max zero-sequence injection.
// A transaction is accepted at a rising edge where start is high and busy is
// low. busy is held low: the pipeline takes a new d/q voltage and angle in
// every cycle. Each transaction yields three compare values on o_result,
// marked by o_done for exactly one cycle. The pipeline has eleven
// register stages: clamp and table index, sine table read, inverse Park
// products, their sums, bus scaling, rounding, sqrt(3)/2 scaling,
// inverse Clarke, min/max, injection with clamp, and the
// period multiply. The receiver cannot stall; results leave in order.
// Configuration writes use i_cfg_valid, o_cfg_ready (always high),
// i_cfg_index and i_cfg_data; they are meant to happen only while the
// pipeline is empty. Unknown indexes are ignored.
// Synchronous active-low reset clears the pipeline valid bits and loads the
// default limit of 6 V, the default inverse bus voltage for 12.123 V and the
// default period of 8500.
module svpwm_min_max_injection import svpwm_pkg::*; #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int VOLT_FRAC_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_svpwm_in   i_cmd,
    output logic        o_done,
    output t_svpwm_out  o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int STAGES = 11;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PRD_W  = ANGLE_BITS + IDX_W + 1;
    localparam int RS     = VOLT_FRAC_BITS + 7;
    localparam int M_W    = 50;
    localparam int AL_W   = M_W + 1 - RS;
    localparam int K_W    = AL_W + 17;
    localparam int U_W    = AL_W + 4;
    localparam int D_W    = U_W + 3;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic signed [M_W:0]   AL_HALF = (M_W + 1)'(1) << (RS - 1);
    localparam logic signed [K_W:0]   KB_HALF = (K_W + 1)'(1) << 15;
    localparam logic signed [D_W-1:0] DUTY_HALF = D_W'(1) << (DUTY_FRAC - 1);
    localparam logic signed [D_W-1:0] DUTY_ONE  = D_W'(1) << DUTY_FRAC;

    typedef logic signed [15:0] t_rom [SINE_TABLE_DEPTH];

    function automatic t_rom build_sine();
        t_rom   rom;
        longint turn;
        longint quad;
        longint z;
        longint z2;
        longint t;
        longint s;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            turn = (longint'(k) <<< 32) / SINE_TABLE_DEPTH;
            quad = turn >>> 30;
            z    = turn & 64'sh3FFF_FFFF;
            if (quad[0]) begin
                z = (64'sd1 <<< 30) - z;
            end
            z2 = (z * z) >>> 30;
            t  = SIN_C9;
            t  = SIN_C7 - ((z2 * t) >>> 30);
            t  = SIN_C5 - ((z2 * t) >>> 30);
            t  = SIN_C3 - ((z2 * t) >>> 30);
            t  = SIN_C1 - ((z2 * t) >>> 30);
            s  = (z * t) >>> 30;
            s  = (s + (64'sd1 <<< 14)) >>> 15;
            if (s > 64'sd32767) begin
                s = 64'sd32767;
            end
            rom[k] = quad[1] ? -16'(s) : 16'(s);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_sine();

    logic [14:0] r_voltage_limit;
    logic [15:0] r_inv_bus;
    logic [15:0] r_pwm_period;
    logic [STAGES-1:0] r_vld;

    logic signed [15:0] r_vq1, r_vd1;
    logic [IDX_W-1:0]   r_sin_idx, r_cos_idx;
    logic signed [15:0] r_vq2, r_vd2, r_sn, r_cs;
    logic signed [31:0] r_p_qs, r_p_dc, r_p_qc, r_p_ds;
    logic signed [32:0] r_al4, r_be4;
    logic signed [M_W-1:0] r_al5, r_be5;
    logic signed [AL_W-1:0] r_al6, r_be6;
    logic signed [AL_W-1:0] r_al7;
    logic signed [K_W-1:0]  r_bek7;
    logic signed [U_W-1:0]  r_ua8, r_ub8, r_uc8;
    logic signed [U_W-1:0]  r_ua9, r_ub9, r_uc9;
    logic signed [U_W:0]    r_sum9;
    logic [DUTY_FRAC:0]     r_da, r_db, r_dc;
    t_svpwm_out             r_result;

    logic [ANGLE_BITS+15:0] ang_ext;
    logic [ANGLE_BITS-1:0]  ang, angc;
    logic [PRD_W-1:0]       prod_s, prod_c;
    logic signed [16:0]     lim_s, vq_ext, vd_ext;
    logic signed [15:0]     vq_cl, vd_cl;
    logic signed [M_W:0]    al_rnd, be_rnd;
    logic signed [K_W:0]    kb_rnd;
    logic signed [AL_W+1:0] kb;
    logic signed [U_W-1:0]  ua, ub, uc, mx, mn;
    logic signed [D_W-1:0]  dsa, dsb, dsc;
    logic [DUTY_FRAC:0]     da, db, dc;

    function automatic logic [DUTY_FRAC:0] sat_duty(input logic signed [D_W-1:0] d);
        logic [DUTY_FRAC:0] res;
        priority if (d < 0) begin
            res = '0;
        end else if (d > DUTY_ONE) begin
            res = DUTY_ONE[DUTY_FRAC:0];
        end else begin
            res = d[DUTY_FRAC:0];
        end
        return res;
    endfunction

    always_comb begin
        ang_ext = {{ANGLE_BITS{1'b0}}, i_cmd.electrical_angle};
        ang     = ang_ext[ANGLE_BITS-1:0];
        angc    = ang + QUARTER;
        prod_s  = PRD_W'(ang) * PRD_W'(SINE_TABLE_DEPTH);
        prod_c  = PRD_W'(angc) * PRD_W'(SINE_TABLE_DEPTH);

        lim_s  = $signed({2'b00, r_voltage_limit});
        vq_ext = 17'(i_cmd.voltage_q);
        vd_ext = 17'(i_cmd.voltage_d);
        priority if (vq_ext > lim_s) begin
            vq_cl = lim_s[15:0];
        end else if (vq_ext < -lim_s) begin
            vq_cl = 16'(-lim_s);
        end else begin
            vq_cl = i_cmd.voltage_q;
        end
        priority if (vd_ext > lim_s) begin
            vd_cl = lim_s[15:0];
        end else if (vd_ext < -lim_s) begin
            vd_cl = 16'(-lim_s);
        end else begin
            vd_cl = i_cmd.voltage_d;
        end

        al_rnd = ((M_W + 1)'(r_al5) + AL_HALF) >>> RS;
        be_rnd = ((M_W + 1)'(r_be5) + AL_HALF) >>> RS;

        kb_rnd = ((K_W + 1)'(r_bek7) + KB_HALF) >>> 16;
        kb     = kb_rnd[AL_W+1:0];
        ua     = U_W'(r_al7) <<< 1;
        ub     = -U_W'(r_al7) + (U_W'(kb) <<< 1);
        uc     = -U_W'(r_al7) - (U_W'(kb) <<< 1);

        mx = r_ua8;
        mn = r_ua8;
        if (r_ub8 > mx) begin
            mx = r_ub8;
        end
        if (r_uc8 > mx) begin
            mx = r_uc8;
        end
        if (r_ub8 < mn) begin
            mn = r_ub8;
        end
        if (r_uc8 < mn) begin
            mn = r_uc8;
        end

        dsa = (D_W'(r_ua9) <<< 1) - D_W'(r_sum9) + DUTY_HALF;
        dsb = (D_W'(r_ub9) <<< 1) - D_W'(r_sum9) + DUTY_HALF;
        dsc = (D_W'(r_uc9) <<< 1) - D_W'(r_sum9) + DUTY_HALF;
        da  = sat_duty(dsa);
        db  = sat_duty(dsb);
        dc  = sat_duty(dsc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_limit <= LIMIT_RESET;
            r_inv_bus       <= INV_BUS_RESET;
            r_pwm_period    <= PERIOD_RESET;
            r_vld           <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], start & ~busy};
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_VOLTAGE_LIMIT: r_voltage_limit <= i_cfg_data[14:0];
                    REG_INV_BUS:       r_inv_bus       <= i_cfg_data;
                    REG_PWM_PERIOD:    r_pwm_period    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vq1     <= vq_cl;
        r_vd1     <= vd_cl;
        r_sin_idx <= IDX_W'(prod_s >> ANGLE_BITS);
        r_cos_idx <= IDX_W'(prod_c >> ANGLE_BITS);

        r_vq2 <= r_vq1;
        r_vd2 <= r_vd1;
        r_sn  <= SINE_ROM[r_sin_idx];
        r_cs  <= SINE_ROM[r_cos_idx];

        r_p_qs <= 32'(r_vq2) * 32'(r_sn);
        r_p_dc <= 32'(r_vd2) * 32'(r_cs);
        r_p_qc <= 32'(r_vq2) * 32'(r_cs);
        r_p_ds <= 32'(r_vd2) * 32'(r_sn);

        r_al4 <= 33'(r_p_dc) - 33'(r_p_qs);
        r_be4 <= 33'(r_p_qc) + 33'(r_p_ds);

        r_al5 <= M_W'(r_al4) * M_W'($signed({1'b0, r_inv_bus}));
        r_be5 <= M_W'(r_be4) * M_W'($signed({1'b0, r_inv_bus}));

        r_al6 <= al_rnd[AL_W-1:0];
        r_be6 <= be_rnd[AL_W-1:0];

        r_al7  <= r_al6;
        r_bek7 <= K_W'(r_be6) * K_W'(HALF_SQRT3_Q16);

        r_ua8 <= ua;
        r_ub8 <= ub;
        r_uc8 <= uc;

        r_ua9  <= r_ua8;
        r_ub9  <= r_ub8;
        r_uc9  <= r_uc8;
        r_sum9 <= (U_W + 1)'(mx) + (U_W + 1)'(mn);

        r_da <= da;
        r_db <= db;
        r_dc <= dc;

        r_result.compare_a <= 16'((43'(r_da) * 43'(r_pwm_period)) >> DUTY_FRAC);
        r_result.compare_b <= 16'((43'(r_db) * 43'(r_pwm_period)) >> DUTY_FRAC);
        r_result.compare_c <= 16'((43'(r_dc) * 43'(r_pwm_period)) >> DUTY_FRAC);
    end

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_vld[STAGES-1];
    assign o_result    = r_result;

endmodule

// ===== sim/svpwm_min_max_injection_test.sv =====
`timescale 1ns / 100ps

module svpwm_min_max_injection_test;
    import svpwm_pkg::*;

    localparam int     ANGLE_W        = 16;
    localparam int     SINE_DEPTH     = 1024;
    localparam int     VOLT_FRAC      = 8;
    localparam int     PIPE_LATENCY   = 11;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam longint SQRT3_HALF_Q16 = 56756;
    localparam longint POLY_C1        = 1686629713;
    localparam longint POLY_C3        = 693598668;
    localparam longint POLY_C5        = 85569306;
    localparam longint POLY_C7        = 5026995;
    localparam longint POLY_C9        = 172272;
    localparam logic [14:0] DEFAULT_LIMIT  = 15'd1536;
    localparam logic [15:0] DEFAULT_INVBUS = 16'd5406;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd8500;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_svpwm_in   i_cmd;
    logic        o_done;
    t_svpwm_out  o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    logic [14:0] limit_reg;
    logic [15:0] inv_bus_reg;
    logic [15:0] period_reg;

    t_svpwm_out compares_due[$];
    t_svpwm_out compare_want;
    int         vectors_sent;
    int         triples_checked;
    int         cfg_writes;
    int         settings_used;
    int         mismatches;
    int         idle_cycles;

    svpwm_min_max_injection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint sine_q15(int unsigned k);
        logic [31:0] turn;
        longint      z;
        longint      z2;
        longint      t;
        longint      s;
        turn = 32'((longint'(k) << 32) / SINE_DEPTH);
        z = longint'(turn[29:0]);
        if (turn[30]) begin
            z = (64'sd1 << 30) - z;
        end
        z2 = (z * z) >>> 30;
        t = POLY_C9;
        t = POLY_C7 - ((z2 * t) >>> 30);
        t = POLY_C5 - ((z2 * t) >>> 30);
        t = POLY_C3 - ((z2 * t) >>> 30);
        t = POLY_C1 - ((z2 * t) >>> 30);
        s = (z * t) >>> 30;
        s = (s + (64'sd1 << 14)) >>> 15;
        if (s > 32767) begin
            s = 32767;
        end
        return turn[31] ? -s : s;
    endfunction

    function automatic longint round_half_up(longint x, int n);
        return (x + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [15:0] duty_to_compare(longint d);
        d = d + (64'sd1 << 25);
        if (d < 0) d = 0;
        if (d > (64'sd1 << 26)) d = 64'sd1 << 26;
        return 16'((d * longint'(period_reg)) >>> 26);
    endfunction

    function automatic t_svpwm_out predict_compares(t_svpwm_in cmd);
        longint      lim;
        longint      vq;
        longint      vd;
        longint      sn;
        longint      cs;
        longint      al;
        longint      be;
        longint      kb;
        longint      ua;
        longint      ub;
        longint      uc;
        longint      mx;
        longint      mn;
        int unsigned ang;
        int unsigned angc;
        t_svpwm_out  res;
        lim = longint'(limit_reg);
        vq = clamp_sym(longint'($signed(cmd.voltage_q)), lim);
        vd = clamp_sym(longint'($signed(cmd.voltage_d)), lim);
        ang = cmd.electrical_angle % (1 << ANGLE_W);
        angc = (ang + (1 << (ANGLE_W - 2))) % (1 << ANGLE_W);
        sn = sine_q15((ang * SINE_DEPTH) >> ANGLE_W);
        cs = sine_q15((angc * SINE_DEPTH) >> ANGLE_W);
        al = -vq * sn + vd * cs;
        be = vq * cs + vd * sn;
        al = round_half_up(al * longint'(inv_bus_reg), VOLT_FRAC + 7);
        be = round_half_up(be * longint'(inv_bus_reg), VOLT_FRAC + 7);
        kb = round_half_up(be * SQRT3_HALF_Q16, 16);
        ua = 2 * al;
        ub = -al + 2 * kb;
        uc = -al - 2 * kb;
        mx = ua;
        mn = ua;
        if (ub > mx) mx = ub;
        if (uc > mx) mx = uc;
        if (ub < mn) mn = ub;
        if (uc < mn) mn = uc;
        res.compare_a = duty_to_compare(2 * ua - (mx + mn));
        res.compare_b = duty_to_compare(2 * ub - (mx + mn));
        res.compare_c = duty_to_compare(2 * uc - (mx + mn));
        return res;
    endfunction

    function automatic t_svpwm_in vec(logic [15:0] q, logic [15:0] d, logic [15:0] a);
        t_svpwm_in cmd;
        cmd.voltage_q = q;
        cmd.voltage_d = d;
        cmd.electrical_angle = a;
        return cmd;
    endfunction

    function automatic logic [15:0] pick_voltage();
        int unsigned lim;
        int unsigned sel;
        lim = limit_reg;
        sel = $urandom_range(0, 9);
        if (sel < 3) return 16'($urandom);
        if (sel < 8) return 16'($urandom_range(0, 2 * lim) - lim);
        if (sel == 8) return 16'(($urandom_range(0, 1) ? lim : -lim) + $urandom_range(0, 4) - 2);
        return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic [15:0] pick_angle();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return 16'($urandom);
        if (sel < 9) return 16'($urandom_range(0, 5) * 10923 + $urandom_range(0, 4) - 2);
        return 16'(($urandom_range(0, 1023) << 6) + ($urandom_range(0, 1) ? 63 : 0));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            triples_checked++;
            if (compares_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_result));
            end else begin
                compare_want = compares_due.pop_front();
                if (o_result.compare_a !== compare_want.compare_a)
                    report_mismatch($sformatf("compare_a got %0d want %0d",
                                              o_result.compare_a, compare_want.compare_a));
                if (o_result.compare_b !== compare_want.compare_b)
                    report_mismatch($sformatf("compare_b got %0d want %0d",
                                              o_result.compare_b, compare_want.compare_b));
                if (o_result.compare_c !== compare_want.compare_c)
                    report_mismatch($sformatf("compare_c got %0d want %0d",
                                              o_result.compare_c, compare_want.compare_c));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1
                || (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", compares_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_vector(input t_svpwm_in cmd);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        compares_due.push_back(predict_compares(cmd));
        vectors_sent++;
    endtask

    task automatic end_burst_and_drain();
        start <= 1'b0;
        while (compares_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_VOLTAGE_LIMIT: limit_reg = data[14:0];
            REG_INV_BUS:       inv_bus_reg = data;
            REG_PWM_PERIOD:    period_reg = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic test_directed_defaults();
        settings_used++;
        send_vector(vec(16'd0, 16'd0, 16'd0));
        send_vector(vec(16'h7FFF, 16'd0, 16'd0));
        send_vector(vec(16'h8000, 16'd0, 16'd16384));
        send_vector(vec(16'd0, 16'h7FFF, 16'd32768));
        send_vector(vec(16'd0, 16'h8000, 16'd49152));
        send_vector(vec(16'd1536, 16'd1536, 16'hFFFF));
        send_vector(vec(-16'sd1536, -16'sd1536, 16'd63));
        send_vector(vec(16'd1537, -16'sd1537, 16'd64));
        send_vector(vec(16'd1000, 16'd200, 16'd10923));
        send_vector(vec(-16'sd1000, 16'd700, 16'd21845));
        end_burst_and_drain();
    endtask

    task automatic test_zero_limit();
        settings_used++;
        write_reg(REG_VOLTAGE_LIMIT, 16'd0);
        send_vector(vec(16'h7FFF, 16'h8000, 16'd12345));
        send_vector(vec(16'h8000, 16'h7FFF, 16'd40000));
        send_vector(vec(16'd1, 16'hFFFF, 16'd0));
        end_burst_and_drain();
    endtask

    task automatic test_zero_bus_reciprocal();
        settings_used++;
        write_reg(REG_VOLTAGE_LIMIT, 16'hFFFF);
        write_reg(REG_INV_BUS, 16'd0);
        send_vector(vec(16'h7FFF, 16'h7FFF, 16'd5000));
        send_vector(vec(16'h8000, 16'd300, 16'd27000));
        send_vector(vec(16'd4000, 16'h8000, 16'd60000));
        end_burst_and_drain();
    endtask

    task automatic test_zero_period();
        settings_used++;
        write_reg(REG_INV_BUS, 16'hFFFF);
        write_reg(REG_PWM_PERIOD, 16'd0);
        send_vector(vec(16'h7FFF, 16'h8000, 16'd100));
        send_vector(vec(16'd0, 16'd0, 16'd32768));
        send_vector(vec(16'd2000, 16'd9000, 16'd50000));
        end_burst_and_drain();
    endtask

    task automatic test_full_scale();
        settings_used++;
        write_reg(REG_PWM_PERIOD, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_vector(vec(16'h7FFF, 16'h7FFF, 16'd0));
        send_vector(vec(16'h8000, 16'h8000, 16'd8192));
        send_vector(vec(16'h7FFF, 16'h8000, 16'd30000));
        send_vector(vec(16'h8000, 16'h7FFF, 16'hFFFF));
        send_vector(vec(16'd16384, 16'd0, 16'd5461));
        send_vector(vec(16'd0, 16'd0, 16'd0));
        end_burst_and_drain();
    endtask

    task automatic apply_random_setting(input bit use_defaults);
        int unsigned sel;
        if (use_defaults) begin
            write_reg(REG_VOLTAGE_LIMIT, 16'(DEFAULT_LIMIT));
            write_reg(REG_INV_BUS, DEFAULT_INVBUS);
            write_reg(REG_PWM_PERIOD, DEFAULT_PERIOD);
            return;
        end
        sel = $urandom_range(0, 5);
        write_reg(REG_VOLTAGE_LIMIT, sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF :
                  sel == 2 ? 16'($urandom) : 16'($urandom_range(64, 4096)));
        sel = $urandom_range(0, 5);
        write_reg(REG_INV_BUS, sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF :
                  sel == 2 ? 16'($urandom) : 16'($urandom_range(2000, 12000)));
        sel = $urandom_range(0, 5);
        write_reg(REG_PWM_PERIOD, sel == 0 ? 16'd1 : sel == 1 ? 16'hFFFF :
                  sel == 2 ? 16'($urandom) : 16'($urandom_range(1000, 20000)));
        if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_UNUSED, 16'($urandom));
        end
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int sent;
        int burst;
        int gap;
        for (int p = 0; p < phases; p++) begin
            apply_random_setting(p == 0);
            settings_used++;
            sent = 0;
            while (sent < per_phase) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && sent < per_phase; b++) begin
                    send_vector(vec(pick_voltage(), pick_voltage(), pick_angle()));
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0 && sent < per_phase) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            end_burst_and_drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_VOLTAGE_LIMIT;
        i_cfg_data <= '0;
        limit_reg = DEFAULT_LIMIT;
        inv_bus_reg = DEFAULT_INVBUS;
        period_reg = DEFAULT_PERIOD;
        vectors_sent = 0;
        triples_checked = 0;
        cfg_writes = 0;
        settings_used = 0;
        mismatches = 0;
        idle_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_zero_limit();
        test_zero_bus_reciprocal();
        test_zero_period();
        test_full_scale();
        test_random_settings(6, 150);

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (compares_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", compares_due.size()));
        end
        $display("Sent %0d voltage vectors across %0d register settings (%0d register writes).",
                 vectors_sent, settings_used, cfg_writes);
        $display("Checked %0d compare triples, %0d mismatches.", triples_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
